@@ rtl/core/deq_pkg.sv @@
// Shared types and codes for the double-ended queue with search.
// Holds the request/result payload structs, opcodes, error codes and cell commands.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned COUNT_W   = 7;

  // Opcodes; codes six and seven act as status.
  localparam logic [OPCODE_W-1:0] OP_STATUS     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd5;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    logic [ERR_W-1:0]         error_code;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty_flag;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
  } rsp_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
    logic search_clear;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/double_ended_queue_with_search.sv @@
// Top level of the double-ended queue with search: command sequencer,
// result register and the chain of deq_cell instances.
// Depends on deq_pkg and deq_cell.
//
// Usage:
//   Requests enter on req (opcode, value) and are accepted at a rising edge
//   with start high and busy low. Each request yields exactly one result on
//   rsp, valid for the single cycle in which done is high; the receiver
//   cannot hold it off, so it must take it then.
//   Status, push and pop requests are taken one per cycle, back to back,
//   while no search holds busy high; each result passes through pend into rsp and done.
//   A search sends a hit wave down the chain, one cell per cycle; busy stays
//   high until the walk counter reaches zero, and the result then passes
//   through pend into rsp and done; no request is taken meanwhile.
//   Front and rear words sit in the first cell of two oppositely ordered
//   word chains, so pushes and pops at either end need no walk down the chain.
//   Reset (rst, synchronous) empties the queue and drops any pending result;
//   stored words are not cleared and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_with_search
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_t                   state;
  state_t                   state_next;
  logic [CW-1:0]            count;
  logic [CW-1:0]            walk;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] popped_r;
  logic [ERR_W-1:0]         err_r;
  logic                     found_r;
  logic                     pend;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     search_done;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_key;
  logic [ERR_W-1:0]         err_now;
  logic signed [DATA_W-1:0] popped_now;

  logic signed [DATA_W-1:0] f_q [DEPTH];
  logic signed [DATA_W-1:0] r_q [DEPTH];
  logic [DEPTH-1:0]         valid_q;
  logic [DEPTH-1:0]         hit_q;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && req.opcode == OP_SEARCH) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (walk == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy        = 1'b0;
    search_done = 1'b0;
    case (state)
      ST_IDLE:   busy = 1'b0;
      ST_SEARCH: begin
        busy        = 1'b1;
        search_done = (walk == '0);
      end
      default:   busy = 1'b1;
    endcase
  end

  assign accept   = start && !busy;
  assign cell_key = busy ? key_r : req.value;

  always_comb begin
    cmd              = '0;
    cmd.push_front   = accept && (req.opcode == OP_PUSH_FRONT) && !full;
    cmd.push_rear    = accept && (req.opcode == OP_PUSH_REAR) && !full;
    cmd.pop_front    = accept && (req.opcode == OP_POP_FRONT) && !empty;
    cmd.pop_rear     = accept && (req.opcode == OP_POP_REAR) && !empty;
    cmd.search_clear = accept && (req.opcode == OP_SEARCH);
  end

  always_comb begin
    err_now    = ERR_OK;
    popped_now = '0;
    case (req.opcode)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        err_now = full ? ERR_FULL : ERR_OK;
      end
      OP_POP_FRONT: begin
        err_now    = empty ? ERR_EMPTY : ERR_OK;
        popped_now = empty ? '0 : f_q[0];
      end
      OP_POP_REAR: begin
        err_now    = empty ? ERR_EMPTY : ERR_OK;
        popped_now = empty ? '0 : r_q[0];
      end
      OP_SEARCH: err_now = ERR_OK;
      default:   err_now = empty ? ERR_EMPTY : ERR_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      walk  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push_front || cmd.push_rear) begin
        count <= count + 1'b1;
      end else if (cmd.pop_front || cmd.pop_rear) begin
        count <= count - 1'b1;
      end
      if (cmd.search_clear) begin
        walk <= CW'(DEPTH);
      end else if (walk != '0) begin
        walk <= walk - 1'b1;
      end
      pend <= (accept && req.opcode != OP_SEARCH) || search_done;
    end
  end

  // Hold the per-request result parts until the result register loads.
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_now;
      err_r    <= err_now;
      found_r  <= 1'b0;
    end else if (search_done) begin
      found_r <= hit_q[DEPTH-1];
    end
    if (cmd.search_clear) begin
      key_r <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      rsp.popped_value  <= popped_r;
      rsp.found         <= found_r;
      rsp.error_code    <= err_r;
      rsp.entry_count   <= COUNT_W'(count);
      rsp.is_empty_flag <= empty;
      rsp.front_value   <= empty ? '0 : f_q[0];
      rsp.rear_value    <= empty ? '0 : r_q[0];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] lf;
    logic signed [DATA_W-1:0] lr;
    logic                     lv;
    logic                     lh;
    logic signed [DATA_W-1:0] rf;
    logic signed [DATA_W-1:0] rr;
    logic                     rv;

    if (i == 0) begin : g_head
      assign lf = cell_key;
      assign lr = cell_key;
      assign lv = 1'b1;
      assign lh = 1'b0;
    end else begin : g_body
      assign lf = f_q[i-1];
      assign lr = r_q[i-1];
      assign lv = valid_q[i-1];
      assign lh = hit_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rf = '0;
      assign rr = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rf = f_q[i+1];
      assign rr = r_q[i+1];
      assign rv = valid_q[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .key         (cell_key),
      .left_f      (lf),
      .left_r      (lr),
      .left_valid  (lv),
      .left_hit    (lh),
      .right_f     (rf),
      .right_r     (rr),
      .right_valid (rv),
      .f_data      (f_q[i]),
      .r_data      (r_q[i]),
      .valid       (valid_q[i]),
      .hit         (hit_q[i])
    );
  end

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    ($countones(valid_q) == int'(count)))
    else $error("entry count disagrees with occupied cells");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(DEPTH)))
    else $error("entry count exceeds depth");

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    search_done |=> (state == ST_IDLE) && pend)
    else $error("search end did not return to idle with a result");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (busy && start) |=> $stable(count))
    else $error("request taken while busy");

endmodule

`default_nettype wire

@@ rtl/core/deq_cell.sv @@
// One cell of the deque chain: a front-ordered word, a rear-ordered word,
// an occupancy bit and one stage of the search hit wave.
// Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
  import deq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cell_cmd_t                cmd,
  input  wire logic signed [DATA_W-1:0] key,
  input  wire logic signed [DATA_W-1:0] left_f,
  input  wire logic signed [DATA_W-1:0] left_r,
  input  wire logic                     left_valid,
  input  wire logic                     left_hit,
  input  wire logic signed [DATA_W-1:0] right_f,
  input  wire logic signed [DATA_W-1:0] right_r,
  input  wire logic                     right_valid,
  output logic signed [DATA_W-1:0]      f_data,
  output logic signed [DATA_W-1:0]      r_data,
  output logic                          valid,
  output logic                          hit
);

  logic slot;

  // First free cell: empty here, occupied (or head of chain) to the left.
  assign slot = !valid && left_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.push_front || cmd.push_rear) begin
      valid <= left_valid;
    end else if (cmd.pop_front || cmd.pop_rear) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_front) begin
      f_data <= left_f;
    end else if (cmd.push_rear && slot) begin
      f_data <= key;
    end else if (cmd.pop_front) begin
      f_data <= right_f;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_rear) begin
      r_data <= left_r;
    end else if (cmd.push_front && slot) begin
      r_data <= key;
    end else if (cmd.pop_rear) begin
      r_data <= right_r;
    end
  end

  // Advance the hit wave one cell per cycle.
  always_ff @(posedge clk) begin
    if (cmd.search_clear) begin
      hit <= 1'b0;
    end else begin
      hit <= left_hit || (valid && (f_data == key));
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_double_ended_queue_with_search.sv @@
// Self-checking testbench for double_ended_queue_with_search: directed and random requests,
// each result compared field by field against a behavioral deque predictor.
// Depends on deq_pkg and the double_ended_queue_with_search RTL.
`timescale 1ns / 1ps

module tb_double_ended_queue_with_search;
  import deq_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = DEPTH + 8;

  localparam int MODE_MIXED = 0;
  localparam int MODE_FILL  = 1;
  localparam int MODE_DRAIN = 2;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  double_ended_queue_with_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #6 clk = ~clk;

  // Predictor state: ring of words, front index and occupancy.
  logic signed [DATA_W-1:0] deque_ring [DEPTH];
  int unsigned deque_front = 0;
  int unsigned deque_count = 0;

  rsp_t expected_rsp [$];
  int   error_total = 0;
  int   idle_pct    = 0;
  int   cycle_count = 0;

  function automatic req_t make_req(input logic [OPCODE_W-1:0] op,
                                    input logic signed [DATA_W-1:0] word);
    req_t r;
    r.opcode = op;
    r.value  = word;
    return r;
  endfunction

  // Apply one request to the predictor and return the result it must produce.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t res;
    res = '0;
    case (r.opcode)
      OP_PUSH_FRONT: begin
        if (deque_count >= DEPTH) begin
          res.error_code = ERR_FULL;
        end else begin
          deque_front = (deque_front + DEPTH - 1) % DEPTH;
          deque_ring[deque_front] = r.value;
          deque_count++;
        end
      end
      OP_PUSH_REAR: begin
        if (deque_count >= DEPTH) begin
          res.error_code = ERR_FULL;
        end else begin
          deque_ring[(deque_front + deque_count) % DEPTH] = r.value;
          deque_count++;
        end
      end
      OP_POP_FRONT: begin
        if (deque_count == 0) begin
          res.error_code = ERR_EMPTY;
        end else begin
          res.popped_value = deque_ring[deque_front];
          deque_front = (deque_front + 1) % DEPTH;
          deque_count--;
        end
      end
      OP_POP_REAR: begin
        if (deque_count == 0) begin
          res.error_code = ERR_EMPTY;
        end else begin
          res.popped_value = deque_ring[(deque_front + deque_count - 1) % DEPTH];
          deque_count--;
        end
      end
      OP_SEARCH: begin
        for (int unsigned i = 0; i < deque_count && !res.found; i++) begin
          if (deque_ring[(deque_front + i) % DEPTH] == r.value) res.found = 1'b1;
        end
      end
      default: begin
        // status and the spare codes: peek on empty is an error
        if (deque_count == 0) res.error_code = ERR_EMPTY;
      end
    endcase
    res.entry_count   = COUNT_W'(deque_count);
    res.is_empty_flag = (deque_count == 0);
    if (deque_count != 0) begin
      res.front_value = deque_ring[deque_front];
      res.rear_value  = deque_ring[(deque_front + deque_count - 1) % DEPTH];
    end
    return res;
  endfunction

  task automatic check_result(input rsp_t exp, input rsp_t act);
    if (act.popped_value !== exp.popped_value) begin
      $error("popped_value: expected %0d, got %0d", exp.popped_value, act.popped_value);
      error_total++;
    end
    if (act.found !== exp.found) begin
      $error("found: expected %0d, got %0d", exp.found, act.found);
      error_total++;
    end
    if (act.error_code !== exp.error_code) begin
      $error("error_code: expected %0d, got %0d", exp.error_code, act.error_code);
      error_total++;
    end
    if (act.entry_count !== exp.entry_count) begin
      $error("entry_count: expected %0d, got %0d", exp.entry_count, act.entry_count);
      error_total++;
    end
    if (act.is_empty_flag !== exp.is_empty_flag) begin
      $error("is_empty_flag: expected %0d, got %0d", exp.is_empty_flag, act.is_empty_flag);
      error_total++;
    end
    if (act.front_value !== exp.front_value) begin
      $error("front_value: expected %0d, got %0d", exp.front_value, act.front_value);
      error_total++;
    end
    if (act.rear_value !== exp.rear_value) begin
      $error("rear_value: expected %0d, got %0d", exp.rear_value, act.rear_value);
      error_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        $error("result with no request outstanding");
        error_total++;
      end else begin
        check_result(expected_rsp.pop_front(), rsp);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hold start until the request is taken, then idle at the current rate.
  task automatic send_request(input req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rsp.push_back(apply_request(r));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drop start for at least one edge and hold until every result is back.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_rsp.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      4, 5, 6: return DATA_W'($urandom_range(7));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_key();
    if (deque_count != 0 && $urandom_range(2) == 0)
      return deque_ring[(deque_front + $urandom_range(deque_count - 1)) % DEPTH];
    return pick_word();
  endfunction

  task automatic test_empty_queue();
    send_request(make_req(OP_STATUS, '0));
    send_request(make_req(OP_POP_FRONT, WORD_MAX));
    send_request(make_req(OP_POP_REAR, WORD_MIN));
    send_request(make_req(OP_SEARCH, '0));
    send_request(make_req(OP_SPARE_6, -1));
    send_request(make_req(OP_SPARE_7, '0));
  endtask

  task automatic test_end_words();
    send_request(make_req(OP_PUSH_FRONT, WORD_MIN));
    send_request(make_req(OP_PUSH_REAR, WORD_MAX));
    send_request(make_req(OP_STATUS, '0));
    send_request(make_req(OP_PUSH_FRONT, -1));
    send_request(make_req(OP_PUSH_REAR, '0));
    send_request(make_req(OP_SPARE_7, WORD_MAX));
  endtask

  task automatic test_search_keys();
    send_request(make_req(OP_SEARCH, WORD_MIN));
    send_request(make_req(OP_SEARCH, WORD_MAX));
    send_request(make_req(OP_SEARCH, 32'sd12345));
    send_request(make_req(OP_SEARCH, -1));
  endtask

  task automatic test_last_word_removal();
    send_request(make_req(OP_POP_REAR, '0));
    send_request(make_req(OP_POP_FRONT, '0));
    send_request(make_req(OP_POP_FRONT, '0));
    send_request(make_req(OP_POP_REAR, '0));
    send_request(make_req(OP_STATUS, '0));
    send_request(make_req(OP_SEARCH, WORD_MIN));
  endtask

  // Runs of fill, drain and mixed traffic so the queue reaches both full and empty.
  task automatic test_random_traffic(input int items, input int first_mode);
    int mode;
    int run_left;
    int roll;
    int push_lim;
    int pop_lim;
    logic [OPCODE_W-1:0] op;
    mode     = first_mode;
    run_left = $urandom_range(160, 80);
    for (int n = 0; n < items; n++) begin
      if (run_left == 0) begin
        mode     = $urandom_range(MODE_DRAIN);
        run_left = $urandom_range(160, 40);
      end
      run_left--;
      case (mode)
        MODE_FILL: begin
          push_lim = 85;
          pop_lim  = 90;
        end
        MODE_DRAIN: begin
          push_lim = 10;
          pop_lim  = 85;
        end
        default: begin
          push_lim = 40;
          pop_lim  = 80;
        end
      endcase
      roll = $urandom_range(99);
      if (roll < push_lim) begin
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        send_request(make_req(op, pick_word()));
      end else if (roll < pop_lim) begin
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
        send_request(make_req(op, $urandom()));
      end else if (roll < pop_lim + 8) begin
        send_request(make_req(OP_SEARCH, pick_key()));
      end else begin
        case ($urandom_range(2))
          0: op = OP_STATUS;
          1: op = OP_SPARE_6;
          default: op = OP_SPARE_7;
        endcase
        send_request(make_req(op, $urandom()));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 0;
    test_empty_queue();
    test_end_words();
    idle_pct = 25;
    test_search_keys();
    test_last_word_removal();
    wait_for_results();

    idle_pct = 0;
    test_random_traffic(300, MODE_FILL);
    // pause until every outstanding result is back
    wait_for_results();
    idle_pct = 74;
    test_random_traffic(300, MODE_FILL);
    wait_for_results();
    idle_pct = 25;
    test_random_traffic(300, MODE_MIXED);
    idle_pct = 0;
    test_random_traffic(300, MODE_FILL);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_total == 0 && expected_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue_with_search.sv
sim/tb_double_ended_queue_with_search.sv
